>>> rtl/dvie_pkg.sv
// ---------------------------------------------------------------------------
// dvie_pkg
// Shared constants, codes and the command record for the DMA video memory
// interleave engine.
// ---------------------------------------------------------------------------
package dvie_pkg;

    // video memory size, power of two between 1 MiB and 16 MiB
    localparam logic [31:0] VRAM_BYTES  = 32'h0080_0000;
    localparam logic [31:0] VRAM_MASK   = VRAM_BYTES - 32'd1;
    localparam logic [31:0] VRAM_ORIGIN = 32'h0500_0000;

    // item kinds
    localparam logic [1:0] OP_REG_READ  = 2'd0;
    localparam logic [1:0] OP_REG_WRITE = 2'd1;
    localparam logic [1:0] OP_DATA_WORD = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    // register offsets
    localparam logic [7:0] REG_DEST      = 8'h00;
    localparam logic [7:0] REG_LENGTH    = 8'h04;
    localparam logic [7:0] REG_START     = 8'h08;
    localparam logic [7:0] REG_MODE_LOW  = 8'h84;
    localparam logic [7:0] REG_MODE_HIGH = 8'h88;

    // destination forms
    localparam logic [1:0] FORM_BUS        = 2'd0;
    localparam logic [1:0] FORM_VRAM_LIN   = 2'd1;
    localparam logic [1:0] FORM_VRAM_INTLV = 2'd2;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic [31:0] read_data;
        logic        wr_valid;
        logic [21:0] word_index;
        logic [1:0]  form;
        logic [31:0] base;
        logic [31:0] word_data;
        logic [28:0] src_addr;
        logic        busy;
        logic        irq;
        logic [31:0] count;
    } t_cmd;

    // queue handshake between the two halves
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

>>> rtl/dma_vram_interleave_engine_core.sv
// ---------------------------------------------------------------------------
// dma_vram_interleave_engine_core
// Register-mapped DMA channel writing a word stream to bus or video memory.
// ---------------------------------------------------------------------------
// Usage: every item enters on the s_axis channel; s_axis_tuser carries the
// item kind (register read, register write, source data word, completion
// tick) and s_axis_tdata the offset, write value, source address and word.
// Every item yields exactly one result on the m_axis channel: register read
// data, the destination word write (flagged by m_axis_tuser), busy, the
// interrupt pulse and the reported count.
// Throughput is one item per cycle while m_axis accepts. The front end
// updates registers and transfer state as it accepts an item; a two-entry
// queue feeds the back end, which forms the destination address and loads
// the output register; each result passes through both before m_axis.
// When the receiver stalls, the output register holds and the queue fills;
// s_axis_tready drops once both queue entries are occupied.
// Synchronous reset clears front registers, busy, queue level, output valid.
// ---------------------------------------------------------------------------
module dma_vram_interleave_engine_core import dvie_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // reg_offset[7:0], write_data[39:8], source_address[68:40],
    // word_data[100:69], zero fill [103:101]
    input  logic [103:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // read_data[31:0], mem_write_address[63:32], mem_write_data[95:64],
    // source_word_address[124:96], busy_flag[125], irq_pulse[126],
    // reported_count[158:127], zero fill [159]
    output logic [159:0]  m_axis_tdata,
    // mem_write_valid[0]
    output logic          m_axis_tuser
);

    logic push;
    logic q_ready;
    logic pop;
    t_cmd front_cmd;
    t_cmd head_cmd;
    t_hs  head_hs;

    assign s_axis_tready = q_ready;

    dvie_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .i_operation      (s_axis_tuser),
        .i_reg_offset     (s_axis_tdata[7:0]),
        .i_write_data     (s_axis_tdata[39:8]),
        .i_source_address (s_axis_tdata[68:40]),
        .i_word_data      (s_axis_tdata[100:69]),
        .i_q_ready        (q_ready),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    dvie_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_cmd     (front_cmd),
        .o_ready   (q_ready),
        .o_head_hs (head_hs),
        .i_pop     (pop),
        .o_head    (head_cmd)
    );

    dvie_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head_hs (head_hs),
        .i_head    (head_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser)
    );

endmodule

>>> rtl/dvie_front.sv
// ---------------------------------------------------------------------------
// dvie_front
// Accepts items, runs the register file and the transfer bookkeeping, and
// emits one classified command per item.
// ---------------------------------------------------------------------------
module dvie_front import dvie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic [28:0] i_source_address,
    input  logic [31:0] i_word_data,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [31:0] r_dest,   n_dest;
    logic [31:0] r_length, n_length;
    logic        r_busy,   n_busy;
    logic        r_mode_lo, n_mode_lo;
    logic        r_mode_hi, n_mode_hi;
    logic [28:0] r_src,    n_src;
    logic [1:0]  r_form,   n_form;
    logic [31:0] r_base,   n_base;
    logic [21:0] r_idx,    n_idx;
    logic [21:0] r_total,  n_total;

    logic        accept;
    logic        win_hit;
    logic        vram_hit;
    logic [31:0] bus_addr;
    logic [23:0] vram_off;
    logic        vram_mode;
    logic [23:0] src_step;

    assign accept = i_valid && i_q_ready;
    assign o_push = accept;

    // destination decode for a start
    assign bus_addr  = r_dest & 32'h1fff_ffe0;
    assign win_hit   = r_dest[28:26] == 3'b100;
    assign vram_hit  = bus_addr[28:25] == 4'b0010;
    assign vram_off  = win_hit ? r_dest[23:0] : bus_addr[23:0];
    assign vram_mode = (win_hit && r_dest[25]) ? r_mode_hi : r_mode_lo;
    assign src_step  = {r_idx, 2'b00};

    // item execution
    always_comb begin
        n_dest    = r_dest;
        n_length  = r_length;
        n_busy    = r_busy;
        n_mode_lo = r_mode_lo;
        n_mode_hi = r_mode_hi;
        n_src     = r_src;
        n_form    = r_form;
        n_base    = r_base;
        n_idx     = r_idx;
        n_total   = r_total;
        o_cmd     = '0;
        o_cmd.form = r_form;
        o_cmd.base = r_base;
        case (i_operation)
            OP_REG_READ: begin
                case (i_reg_offset)
                    REG_DEST:      o_cmd.read_data = r_dest;
                    REG_LENGTH:    o_cmd.read_data = r_length;
                    REG_START:     o_cmd.read_data = {31'd0, r_busy};
                    REG_MODE_LOW:  o_cmd.read_data = {31'd0, r_mode_lo};
                    REG_MODE_HIGH: o_cmd.read_data = {31'd0, r_mode_hi};
                    default:       o_cmd.read_data = '0;
                endcase
            end
            OP_REG_WRITE: begin
                case (i_reg_offset)
                    REG_DEST:      n_dest = i_write_data;
                    REG_LENGTH:    n_length = i_write_data;
                    REG_START: begin
                        if (i_write_data[0] && !r_busy) begin
                            if (win_hit || vram_hit) begin
                                if (vram_mode) begin
                                    n_form = FORM_VRAM_LIN;
                                    n_base = VRAM_ORIGIN + ({8'd0, vram_off} & VRAM_MASK);
                                end else begin
                                    n_form = FORM_VRAM_INTLV;
                                    n_base = {8'd0, vram_off};
                                end
                            end else begin
                                n_form = FORM_BUS;
                                n_base = bus_addr;
                            end
                            n_src   = i_source_address;
                            n_total = {r_length[23:5], 3'b000};
                            n_idx   = '0;
                            n_busy  = 1'b1;
                        end
                    end
                    REG_MODE_LOW:  n_mode_lo = i_write_data[0];
                    REG_MODE_HIGH: n_mode_hi = i_write_data[0];
                    default: ;
                endcase
            end
            OP_DATA_WORD: begin
                if (r_busy && (r_idx < r_total)) begin
                    o_cmd.wr_valid   = 1'b1;
                    o_cmd.word_index = r_idx;
                    o_cmd.word_data  = i_word_data;
                    o_cmd.src_addr   = r_src + {5'd0, src_step};
                    n_idx            = r_idx + 22'd1;
                end
            end
            OP_TICK: begin
                if (r_busy && (r_idx >= r_total)) begin
                    o_cmd.count = r_length;
                    o_cmd.irq   = 1'b1;
                    n_dest      = r_dest + r_length;
                    n_length    = '0;
                    n_busy      = 1'b0;
                end
            end
            default: ;
        endcase
        o_cmd.busy = n_busy;
    end

    // state registers, updated only on an accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest    <= '0;
            r_length  <= '0;
            r_busy    <= 1'b0;
            r_mode_lo <= 1'b0;
            r_mode_hi <= 1'b0;
            r_src     <= '0;
            r_form    <= FORM_BUS;
            r_base    <= '0;
            r_idx     <= '0;
            r_total   <= '0;
        end else if (accept) begin
            r_dest    <= n_dest;
            r_length  <= n_length;
            r_busy    <= n_busy;
            r_mode_lo <= n_mode_lo;
            r_mode_hi <= n_mode_hi;
            r_src     <= n_src;
            r_form    <= n_form;
            r_base    <= n_base;
            r_idx     <= n_idx;
            r_total   <= n_total;
        end
    end

endmodule

>>> rtl/dvie_queue.sv
// ---------------------------------------------------------------------------
// dvie_queue
// Two-entry command queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module dvie_queue import dvie_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output t_hs  o_head_hs,
    input  logic i_pop,
    output t_cmd o_head
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_ready         = r_count != 2'd2;
    assign do_push         = i_push && o_ready;
    assign do_pop          = i_pop && (r_count != 2'd0);
    assign o_head          = r_mem[r_rptr];
    assign o_head_hs.valid = r_count != 2'd0;
    assign o_head_hs.ready = o_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/dvie_back.sv
// ---------------------------------------------------------------------------
// dvie_back
// Forms the destination address of each word write (linear or 64-bit bank
// interleave) and holds the result in the output register.
// ---------------------------------------------------------------------------
module dvie_back import dvie_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_hs           i_head_hs,
    input  t_cmd          i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [159:0]  o_data,
    output logic          o_user
);

    logic         r_valid;
    logic [159:0] r_data;
    logic         r_user;
    logic [31:0]  lin_addr;
    logic [31:0]  ilv_word;
    logic [31:0]  wr_addr;

    assign o_pop = i_head_hs.valid && (!r_valid || i_ready);

    // destination address of the word
    assign lin_addr = i_head.base + {8'd0, i_head.word_index, 2'b00};
    assign ilv_word = {1'b0, lin_addr[31:3], lin_addr[1:0]}
                    + {9'd0, lin_addr[2], 22'd0};
    always_comb begin
        if (!i_head.wr_valid) begin
            wr_addr = '0;
        end else if (i_head.form == FORM_VRAM_INTLV) begin
            wr_addr = VRAM_ORIGIN + (ilv_word & VRAM_MASK);
        end else begin
            wr_addr = lin_addr;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= {1'b0, i_head.count, i_head.irq, i_head.busy, i_head.src_addr,
                       i_head.word_data, wr_addr, i_head.read_data};
            r_user <= i_head.wr_valid;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

endmodule
